FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the compensation RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/core/btpc_pkg.sv
// Shared types and constants for the pressure/temperature compensation.
// No dependencies.
`default_nettype none
package btpc_pkg;
    localparam int IdxW = 3;
    localparam logic [IdxW-1:0] RegAc1 = 3'd0;
    localparam logic [IdxW-1:0] RegAc2 = 3'd1;
    localparam logic [IdxW-1:0] RegAc3 = 3'd2;
    localparam logic [IdxW-1:0] RegAc4 = 3'd3;
    localparam logic [IdxW-1:0] RegAc5 = 3'd4;
    localparam logic [IdxW-1:0] RegAc6 = 3'd5;
    localparam logic [IdxW-1:0] RegB1B2 = 3'd6;
    localparam logic [IdxW-1:0] RegMcMd = 3'd7;
    localparam int DivSteps = 32;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [4:0] {
        OP_T_X1,   // x1 = ((raw-ac6)*ac5) >>> 15 (trunc)
        OP_T_DEN,  // start divide mc*2048 / den (den = acc = x1 + md)
        OP_T_FIN,  // b5 = x1 + q ; val
        OP_P_B6,   // b6, sq
        OP_P_X1,   // x1 = b2*sq/2048
        OP_P_X2,   // acc = x1 + ac2*b6/2048
        OP_P_B3,
        OP_P_X3A,  // ac3*b6/8192
        OP_P_X3B,  // b1*sq/65536; x3
        OP_P_B4,   // b4
        OP_P_B7,   // b7 and start divide
        OP_P_P,    // p from quotient
        OP_P_Y1,   // (p/256)^2
        OP_P_Y2,   // *3038/65536
        OP_P_Y3,   // -7357*p/65536
        OP_P_FIN
    } op_t;

    typedef struct packed {
        logic load;
        logic op_en;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_zero;
    } sts_t;

    function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
                                                    input int unsigned sh);
        logic signed [31:0] bias;
        bias = a[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
        return (a + bias) >>> sh;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/btpc_div.sv
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// Depends on btpc_pkg.
`default_nettype none
module btpc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [31:0]      quotient
);
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dsr_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'(btpc_pkg::DivSteps);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;
endmodule
`default_nettype wire

FILE: rtl/core/btpc_dp.sv
// Datapath: calibration registers, B5 store, two multipliers, divider.
// Depends on btpc_pkg and btpc_div.
`default_nettype none
module btpc_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               kind,
    input  wire logic [15:0]        raw_value,
    input  wire btpc_pkg::cmd_t     cmd,
    output btpc_pkg::sts_t          sts,
    output logic                    res_kind,
    output logic [31:0]             res_value,
    output logic                    res_err
);
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, ac5_reg, ac6_reg;
    logic [31:0] b1b2_reg, mcmd_reg;
    logic signed [31:0] b5_reg;
    logic        kind_reg;
    logic [15:0] raw_reg;
    logic signed [31:0] x1_reg, acc_reg, b6_reg, sq_reg, b3_reg, p_reg, t_reg;
    logic [31:0] b4_reg, b7_reg;
    logic signed [31:0] val_reg;
    logic        err_reg;
    logic        neg_reg;

    logic signed [31:0] ma, mb, prod;
    logic        dstart;
    logic [31:0] ddend, ddsr, dquo;
    logic        dbusy;
    logic signed [31:0] sq_q;
    logic signed [31:0] md_s, mc_s, b1_s, b2_s;
    logic [31:0] b4_prod;
    logic [31:0] magn, magd;

    assign mc_s = 32'(signed'(mcmd_reg[31:16]));
    assign md_s = 32'(signed'(mcmd_reg[15:0]));
    assign b1_s = 32'(signed'(b1b2_reg[31:16]));
    assign b2_s = 32'(signed'(b1b2_reg[15:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg <= '0; ac2_reg <= '0; ac3_reg <= '0;
            ac4_reg <= '0; ac5_reg <= '0; ac6_reg <= '0;
            b1b2_reg <= '0; mcmd_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                btpc_pkg::RegAc1:  ac1_reg <= cfg_data[15:0];
                btpc_pkg::RegAc2:  ac2_reg <= cfg_data[15:0];
                btpc_pkg::RegAc3:  ac3_reg <= cfg_data[15:0];
                btpc_pkg::RegAc4:  ac4_reg <= cfg_data[15:0];
                btpc_pkg::RegAc5:  ac5_reg <= cfg_data[15:0];
                btpc_pkg::RegAc6:  ac6_reg <= cfg_data[15:0];
                btpc_pkg::RegB1B2: b1b2_reg <= cfg_data;
                btpc_pkg::RegMcMd: mcmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Multiplier operand select; one 32x32 product per op, wrapped.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            btpc_pkg::OP_T_X1:  begin ma = 32'(signed'({16'd0, raw_reg}) - signed'({16'd0, ac6_reg})); mb = {16'd0, ac5_reg}; end
            btpc_pkg::OP_P_B6:  begin ma = b5_reg - 32'sd4000; mb = b5_reg - 32'sd4000; end
            btpc_pkg::OP_P_X1:  begin ma = b2_s; mb = sq_reg; end
            btpc_pkg::OP_P_X2:  begin ma = 32'(signed'(ac2_reg)); mb = b6_reg; end
            btpc_pkg::OP_P_X3A: begin ma = 32'(signed'(ac3_reg)); mb = b6_reg; end
            btpc_pkg::OP_P_X3B: begin ma = b1_s; mb = sq_reg; end
            btpc_pkg::OP_P_B7:  begin ma = 32'({16'd0, raw_reg}) - b3_reg; mb = 32'sd50000; end
            btpc_pkg::OP_P_Y1:  begin ma = btpc_pkg::sdiv_pow2(p_reg, 8); mb = btpc_pkg::sdiv_pow2(p_reg, 8); end
            btpc_pkg::OP_P_Y2:  begin ma = t_reg; mb = 32'sd3038; end
            btpc_pkg::OP_P_Y3:  begin ma = -32'sd7357; mb = p_reg; end
            default: ;
        endcase
    end
    assign prod    = 32'(ma * mb);
    assign sq_q    = btpc_pkg::sdiv_pow2(prod, 12);
    assign b4_prod = 32'(ac4_reg * (32'(acc_reg) + 32'd32768));

    // Magnitudes for the signed temperature division mc*2048 / den.
    assign magn = mc_s[31] ? 32'(-(mc_s <<< 11)) : 32'(mc_s <<< 11);
    assign magd = acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);

    always_comb
    begin
        dstart = 1'b0;
        ddend  = magn;
        ddsr   = magd;
        if (cmd.op_en && cmd.op == btpc_pkg::OP_T_DEN)
        begin
            dstart = (acc_reg != 0);
        end
        else if (cmd.op_en && cmd.op == btpc_pkg::OP_P_B7)
        begin
            dstart = (b4_reg != '0);
            ddend  = (prod[31] == 1'b0) ? {prod[30:0], 1'b0} : prod;
            ddsr   = b4_reg;
        end
    end

    btpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart),
        .dividend (ddend),
        .divisor  (ddsr),
        .busy     (dbusy),
        .quotient (dquo)
    );

    assign sts.div_busy = dbusy;
    assign sts.div_zero = (cmd.op == btpc_pkg::OP_T_DEN) ? (acc_reg == 0) : (b4_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b5_reg <= '0;
        end
        else if (cmd.op_en && cmd.op == btpc_pkg::OP_T_FIN)
        begin
            b5_reg <= x1_reg + (neg_reg ? 32'(-dquo) : 32'(dquo));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            raw_reg  <= raw_value;
            err_reg  <= 1'b0;
            val_reg  <= '0;
        end
        else if (cmd.op_en)
        begin
            case (cmd.op)
                btpc_pkg::OP_T_X1:  begin x1_reg <= btpc_pkg::sdiv_pow2(prod, 15); acc_reg <= btpc_pkg::sdiv_pow2(prod, 15) + md_s; end
                btpc_pkg::OP_T_DEN:
                begin
                    neg_reg <= mc_s[31] ^ acc_reg[31];
                    if (acc_reg == 0) err_reg <= 1'b1;
                end
                btpc_pkg::OP_T_FIN:
                begin
                    val_reg <= btpc_pkg::sdiv_pow2(x1_reg + (neg_reg ? 32'(-dquo) : 32'(dquo)) + 32'sd8, 4);
                end
                btpc_pkg::OP_P_B6:  begin b6_reg <= b5_reg - 32'sd4000; sq_reg <= sq_q; end
                btpc_pkg::OP_P_X1:  x1_reg <= btpc_pkg::sdiv_pow2(prod, 11);
                btpc_pkg::OP_P_X2:  acc_reg <= x1_reg + btpc_pkg::sdiv_pow2(prod, 11);
                btpc_pkg::OP_P_B3:  b3_reg <= btpc_pkg::sdiv_pow2((32'(signed'(ac1_reg)) <<< 2) + acc_reg + 32'sd2, 2);
                btpc_pkg::OP_P_X3A: x1_reg <= btpc_pkg::sdiv_pow2(prod, 13);
                btpc_pkg::OP_P_X3B: acc_reg <= btpc_pkg::sdiv_pow2(x1_reg + btpc_pkg::sdiv_pow2(prod, 16) + 32'sd2, 2);
                btpc_pkg::OP_P_B4:  b4_reg <= b4_prod >> 15;
                btpc_pkg::OP_P_B7:
                begin
                    b7_reg <= prod;
                    if (b4_reg == '0) err_reg <= 1'b1;
                end
                btpc_pkg::OP_P_P:   p_reg <= b7_reg[31] ? signed'({dquo[30:0], 1'b0}) : signed'(dquo);
                btpc_pkg::OP_P_Y1:  t_reg <= prod;
                btpc_pkg::OP_P_Y2:  t_reg <= btpc_pkg::sdiv_pow2(prod, 16);
                btpc_pkg::OP_P_Y3:  acc_reg <= t_reg + btpc_pkg::sdiv_pow2(prod, 16) + 32'sd3791;
                btpc_pkg::OP_P_FIN: val_reg <= p_reg + btpc_pkg::sdiv_pow2(acc_reg, 4);
                default: ;
            endcase
        end
    end

    assign res_kind  = kind_reg;
    assign res_value = val_reg;
    assign res_err   = err_reg;
endmodule
`default_nettype wire

FILE: rtl/core/btpc_ctrl.sv
// Controller: sequences datapath operations and runs both handshakes.
// Depends on btpc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module btpc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           kind,
    output logic                out_valid,
    input  wire logic           out_stall,
    output btpc_pkg::cmd_t      cmd,
    input  wire btpc_pkg::sts_t sts
);
    typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} state_t;
    state_t state_reg;
    btpc_pkg::op_t op_reg;
    logic out_valid_reg;
    logic accept;
    logic last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign last      = (op_reg == btpc_pkg::OP_T_FIN) || (op_reg == btpc_pkg::OP_P_FIN);

    always_comb
    begin
        cmd.load  = accept;
        cmd.op    = op_reg;
        cmd.op_en = (state_reg == ST_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= btpc_pkg::OP_T_X1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        state_reg <= ST_RUN;
                        op_reg    <= kind ? btpc_pkg::OP_P_B6 : btpc_pkg::OP_T_X1;
                    end
                ST_RUN:
                begin
                    if (last)
                    begin
                        state_reg     <= ST_DONE;
                        out_valid_reg <= 1'b1;
                    end
                    else if ((op_reg == btpc_pkg::OP_T_DEN || op_reg == btpc_pkg::OP_P_B7)
                             && sts.div_zero)
                    begin
                        // zero divisor: result already forced
                        state_reg     <= ST_DONE;
                        out_valid_reg <= 1'b1;
                    end
                    else if (op_reg == btpc_pkg::OP_T_DEN || op_reg == btpc_pkg::OP_P_B7)
                    begin
                        state_reg <= ST_WAIT;
                        op_reg    <= btpc_pkg::op_t'(op_reg + 5'd1);
                    end
                    else
                    begin
                        op_reg <= btpc_pkg::op_t'(op_reg + 5'd1);
                    end
                end
                ST_WAIT:
                    if (!sts.div_busy) state_reg <= ST_RUN;
                ST_DONE:
                    if (!out_stall)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_valid_done, clk, rst_n, out_valid, state_reg == ST_DONE)
    `ASSERT_NEXT(a_accept_run, clk, rst_n, accept, state_reg == ST_RUN)
    `ASSERT_IMPLIES(a_wait_div, clk, rst_n, state_reg == ST_WAIT, !out_valid)
endmodule
`default_nettype wire

FILE: rtl/core/baro_temp_pressure_compensation.sv
// Pressure/temperature compensation top level.
// One item in flight: the next transfer in can be taken in the cycle after the result
// transfer. The 32-step divider dominates the time per item; a zero divisor ends the
// item early.
// Reset: asynchronous, clears calibration registers, stored B5 and control.
// Depends on btpc_pkg, btpc_ctrl, btpc_dp.
`default_nettype none
module baro_temp_pressure_compensation (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [15:0] raw_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic [31:0]      value,
    output logic             div_error
);
    btpc_pkg::cmd_t cmd;
    btpc_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    btpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .sts(sts)
    );

    btpc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .kind(kind), .raw_value(raw_value), .cmd(cmd),
        .sts(sts), .res_kind(result_kind), .res_value(value), .res_err(div_error)
    );
endmodule
`default_nettype wire

FILE: sim/baro_temp_pressure_compensation_test.sv
// Self-checking bench for the pressure/temperature compensation block.
// Predicts each result from its own copy of the compensation arithmetic and stored B5.
// Depends on btpc_pkg and baro_temp_pressure_compensation.
`timescale 1ns / 100ps
`default_nettype none
module baro_temp_pressure_compensation_test;

    localparam int WatchLimit = 20000;
    localparam int SettleCycles = 80;

    typedef struct packed {
        logic        kind;
        logic [15:0] raw;
    } reading_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        err;
    } comp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [15:0] raw_value;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [31:0] value;
    logic        div_error;

    baro_temp_pressure_compensation u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .raw_value(raw_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .value(value), .div_error(div_error)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Calibration shadow and stored B5
    logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
    logic [31:0] b1b2, mcmd;
    logic signed [31:0] b5_held;

    reading_t pending_readings[$];
    comp_t    expected_results[$];
    int       mismatches;
    int       idle_cycles;
    int       hold_off;
    bit       timed_out;

    function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        if (b == 0)
            return 0;
        if (b == -1)
            return -a;
        return a / b;
    endfunction

    function automatic logic signed [31:0] sx(input logic [15:0] v);
        return 32'($signed(v));
    endfunction

    // Compensate one reading; updates the stored B5 on a good temperature
    function automatic comp_t compensate(input reading_t r);
        comp_t c;
        logic signed [31:0] rawv, x1, x2, x3, den, b5, b6, sq, b3, p;
        logic [31:0] b4, b7, pu;
        rawv = {16'd0, r.raw};
        c.kind = r.kind;
        c.value = '0;
        c.err = 1'b0;
        if (!r.kind)
        begin
            x1 = tdiv((rawv - $signed({16'd0, ac6})) * $signed({16'd0, ac5}), 32768);
            den = x1 + sx(mcmd[15:0]);
            if (den == 0)
                c.err = 1'b1;
            else
            begin
                x2 = tdiv(sx(mcmd[31:16]) * 2048, den);
                b5 = x1 + x2;
                b5_held = b5;
                c.value = tdiv(b5 + 8, 16);
            end
        end
        else
        begin
            b6 = b5_held - 4000;
            sq = tdiv(b6 * b6, 4096);
            x1 = tdiv(sx(b1b2[15:0]) * sq, 2048);
            x2 = tdiv(sx(ac2) * b6, 2048);
            x3 = x1 + x2;
            b3 = tdiv(sx(ac1) * 4 + x3 + 2, 4);
            x1 = tdiv(sx(ac3) * b6, 8192);
            x2 = tdiv(sx(b1b2[31:16]) * sq, 65536);
            x3 = tdiv(x1 + x2 + 2, 4);
            b4 = ({16'd0, ac4} * ($unsigned(x3) + 32'd32768)) / 32'd32768;
            b7 = ($unsigned(rawv) - $unsigned(b3)) * 32'd50000;
            if (b4 == 0)
                c.err = 1'b1;
            else
            begin
                if (b7 < 32'h8000_0000)
                    pu = (b7 * 32'd2) / b4;
                else
                    pu = (b7 / b4) * 32'd2;
                p = $signed(pu);
                x1 = tdiv(p, 256) * tdiv(p, 256);
                x1 = tdiv(x1 * 3038, 65536);
                x2 = tdiv(-32'sd7357 * p, 65536);
                c.value = p + tdiv(x1 + x2 + 3791, 16);
            end
        end
        return c;
    endfunction

    // Driver: predict at the transfer so B5 follows acceptance order
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 1'b0;
            raw_value <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(compensate({kind, raw_value}));
                in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_readings.size() > 0)
                begin
                    reading_t r;
                    r = pending_readings.pop_front();
                    in_valid <= 1'b1;
                    kind <= r.kind;
                    raw_value <= r.raw;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
            idle_cycles = 0;
        end
        else
        begin
            comp_t got, want;
            idle_cycles++;
            if (in_valid && !in_stall)
                idle_cycles = 0;
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                got = {result_kind, value, div_error};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d value=%0d err=%0d",
                                 result_kind, $signed(value), div_error);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp kind=%0d value=%0d err=%0d,",
                                      " got kind=%0d value=%0d err=%0d"},
                                     want.kind, $signed(want.value), want.err,
                                     got.kind, $signed(got.value), got.err);
                    end
                end
                out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
            if (idle_cycles >= WatchLimit)
                timed_out = 1'b1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            btpc_pkg::RegAc1:  ac1 = data[15:0];
            btpc_pkg::RegAc2:  ac2 = data[15:0];
            btpc_pkg::RegAc3:  ac3 = data[15:0];
            btpc_pkg::RegAc4:  ac4 = data[15:0];
            btpc_pkg::RegAc5:  ac5 = data[15:0];
            btpc_pkg::RegAc6:  ac6 = data[15:0];
            btpc_pkg::RegB1B2: b1b2 = data;
            default: mcmd = data;
        endcase
    endtask

    // Datasheet-like coefficients, or raw random / extreme patterns
    task automatic load_calibration(input int style);
        logic [31:0] w[8];
        for (int i = 0; i < 8; i++)
            w[i] = $urandom();
        if (style == 0)
        begin
            w[0] = 408;   w[1] = -72 & 32'hffff; w[2] = -14383 & 32'hffff;
            w[3] = 32741; w[4] = 32757; w[5] = 23153;
            w[6] = {16'd6190, 16'd4};
            w[7] = {16'h8000 | 16'd24894 ^ 16'h8000 ^ 16'h8000, 16'd2868};
            w[7][31:16] = -16'sd8711;
        end
        else if (style == 1)
            for (int i = 0; i < 8; i++)
                w[i] = 32'hffff_ffff;
        else if (style == 2)
            for (int i = 0; i < 8; i++)
                w[i] = (i < 3) ? 32'h0000_8000 : 32'h8000_8000;
        write_reg(btpc_pkg::RegAc1, w[0]);
        write_reg(btpc_pkg::RegAc2, w[1]);
        write_reg(btpc_pkg::RegAc3, w[2]);
        write_reg(btpc_pkg::RegAc4, w[3]);
        write_reg(btpc_pkg::RegAc5, w[4]);
        write_reg(btpc_pkg::RegAc6, w[5]);
        write_reg(btpc_pkg::RegB1B2, w[6]);
        write_reg(btpc_pkg::RegMcMd, w[7]);
    endtask

    task automatic drain();
        while ((pending_readings.size() > 0 || in_valid || expected_results.size() > 0)
               && !timed_out)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic push(input logic k, input logic [15:0] r);
        pending_readings.push_back({k, r});
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ac1 = '0; ac2 = '0; ac3 = '0; ac4 = '0; ac5 = '0; ac6 = '0;
        b1b2 = '0; mcmd = '0;
        b5_held = '0;
        mismatches = 0;
        hold_off = 0;
        timed_out = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // All zero: pressure before temperature, both divisors zero
        push(1'b1, 16'd23843);
        push(1'b0, 16'd27898);
        push(1'b1, 16'hffff);
        drain();

        load_calibration(0);
        push(1'b1, 16'd23843);
        push(1'b0, 16'd27898);
        push(1'b1, 16'd23843);
        push(1'b0, 16'h0000);
        push(1'b1, 16'h0000);
        push(1'b0, 16'hffff);
        push(1'b1, 16'hffff);
        push(1'b1, 16'h8000);
        push(1'b0, 16'h7fff);
        drain();

        // Temperature divisor zero: ac5 = 0 so x1 = 0, md = 0
        write_reg(btpc_pkg::RegAc5, 32'd0);
        write_reg(btpc_pkg::RegMcMd, {16'd100, 16'd0});
        push(1'b0, 16'd1234);
        push(1'b1, 16'd40000);
        drain();

        for (int s = 1; s < 4; s++)
        begin
            load_calibration(s);
            push(1'b0, 16'h0000);
            push(1'b1, 16'hffff);
            push(1'b0, 16'hffff);
            push(1'b1, 16'h0000);
            drain();
        end

        // Long receiver hold-off while readings keep arriving
        for (int i = 0; i < 20; i++)
            push(i[0], 16'($urandom()));
        hold_off = 400;
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            load_calibration(phase % 2 == 0 ? 0 : 3);
            for (int i = 0; i < 255; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push(1'($urandom_range(0, 1)), 16'($urandom()));
                else
                    push(i[0], i[0] ? 16'($urandom_range(15000, 45000))
                                    : 16'($urandom_range(20000, 32000)));
            end
            drain();
        end

        if (timed_out)
            $display("[FAIL] regression broken");
        else if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
